/* rtl/core/rca_pkg.sv */
// ---------------------------------------------------------------------------
// rca_pkg: shared types and constants of the RGB colour adjustment unit
// Fixed-point format, derived widths, coefficients and register map.
// ---------------------------------------------------------------------------
`default_nettype none

package rca_pkg;

   localparam int FRAC_BITS = 12;
   localparam int REG_W     = 13;
   localparam int BYTE_W    = 8;
   localparam int NUM_CH    = 3;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int BASE_W = (FRAC_BITS > REG_W) ? FRAC_BITS : REG_W;
   localparam int GAIN_B = (FRAC_BITS >= REG_W) ? 0 : REG_W - FRAC_BITS;
   localparam int FACT_B = BASE_W + 1 - FRAC_BITS;
   localparam int FACT_W = BASE_W + 3;
   localparam int DIST_W = BASE_W + 1;
   localparam int COEF_W = FRAC_BITS + 1;
   localparam int CH_W   = FRAC_BITS + BYTE_W + FACT_B + 3 * GAIN_B + 5;
   localparam int PROD_W = CH_W + REG_W + 1;

   localparam int ONE_Q   = 1 << FRAC_BITS;
   localparam int HALF_Q  = 1 << (FRAC_BITS - 1);
   localparam int K_FOUR  = (2 * (4 << FRAC_BITS) + 10) / 20;
   localparam int K_THREE = (2 * (3 << FRAC_BITS) + 10) / 20;
   localparam int K_YR    = (2 * (299 << FRAC_BITS) + 1000) / 2000;
   localparam int K_YG    = (2 * (587 << FRAC_BITS) + 1000) / 2000;
   localparam int K_YB    = ONE_Q - K_YR - K_YG;
   localparam int MID_Q   = 255 << (FRAC_BITS - 1);
   localparam int TOP_Q   = 255 << FRAC_BITS;

   localparam logic [REG_W-1:0] EXPOSURE_RST   = REG_W'(4506);
   localparam logic [REG_W-1:0] CONTRAST_RST   = REG_W'(4710);
   localparam logic [REG_W-1:0] SATURATION_RST = REG_W'(4915);
   localparam logic [REG_W-1:0] WARMTH_RST     = REG_W'(2048);

   typedef enum logic [1:0] {
      REG_EXPOSURE   = 2'd0,
      REG_CONTRAST   = 2'd1,
      REG_SATURATION = 2'd2,
      REG_WARMTH     = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [REG_W-1:0] exposure_gain;
      logic [REG_W-1:0] contrast_gain;
      logic [REG_W-1:0] saturation_gain;
      logic [REG_W-1:0] warmth_level;
   } cfg_type;

   typedef struct packed {
      logic              last;
      logic [BYTE_W-1:0] blue;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] red;
   } pix_type;

   typedef logic signed [CH_W-1:0]   chan_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [FACT_W-1:0] fact_type;

endpackage

`default_nettype wire

/* rtl/core/rca_pipe.sv */
// ---------------------------------------------------------------------------
// rca_pipe: colour adjustment datapath
// Eleven register stages: warmth factors, warmth, exposure, contrast, luma
// and saturation, then clamp to a byte. The whole pipe advances on en.
// ---------------------------------------------------------------------------
`default_nettype none

module rca_pipe (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire rca_pkg::pix_type in_pix,
   input  wire rca_pkg::cfg_type cfg,
   output logic                  out_valid,
   output rca_pkg::pix_type      out_pix
);

   localparam int NSTAGE = 11;
   localparam int BW     = rca_pkg::DIST_W + rca_pkg::COEF_W;
   localparam int FB     = rca_pkg::FRAC_BITS;
   localparam int NC     = rca_pkg::NUM_CH;

   logic [NSTAGE-1:0] vld_ff, vld_in;
   logic [NSTAGE-1:0] last_ff, last_in;

   logic [rca_pkg::BYTE_W-1:0] pix0_ff [NC];
   logic [rca_pkg::BYTE_W-1:0] pix0_in [NC];
   rca_pkg::fact_type fr_ff, fr_in, fb_ff, fb_in;
   rca_pkg::chan_type c2_ff [NC], c2_in [NC];
   rca_pkg::prod_type pe_ff [NC], pe_in [NC];
   rca_pkg::chan_type dc_ff [NC], dc_in [NC];
   rca_pkg::prod_type pc_ff [NC], pc_in [NC];
   rca_pkg::chan_type t6_ff [NC], t6_in [NC];
   rca_pkg::prod_type lp_ff [NC], lp_in [NC];
   rca_pkg::chan_type t7_ff [NC], t7_in [NC];
   rca_pkg::chan_type t8_ff [NC], t8_in [NC];
   rca_pkg::chan_type y_ff, y_in;
   rca_pkg::chan_type sd_ff [NC], sd_in [NC];
   rca_pkg::chan_type y9_ff, y9_in;
   rca_pkg::prod_type ps_ff [NC], ps_in [NC];
   rca_pkg::chan_type y10_ff, y10_in;
   logic [rca_pkg::BYTE_W-1:0] lvl_ff [NC];
   logic [rca_pkg::BYTE_W-1:0] lvl_in [NC];

   logic [rca_pkg::DIST_W-1:0] warm_lvl, half_lvl, warm_dist;
   logic                       warm;
   logic [BW-1:0]              boost, cut;
   rca_pkg::fact_type          fact_up, fact_dn;
   rca_pkg::prod_type          luma_sum;
   rca_pkg::chan_type          mix [NC];
   rca_pkg::prod_type          coef [NC];

   assign vld_in  = {vld_ff[NSTAGE-2:0], in_valid};
   assign last_in = {last_ff[NSTAGE-2:0], in_pix.last};

   assign coef[0] = rca_pkg::prod_type'(rca_pkg::K_YR);
   assign coef[1] = rca_pkg::prod_type'(rca_pkg::K_YG);
   assign coef[2] = rca_pkg::prod_type'(rca_pkg::K_YB);

   always_comb begin
      warm_lvl  = rca_pkg::DIST_W'(cfg.warmth_level);
      half_lvl  = rca_pkg::DIST_W'(rca_pkg::HALF_Q);
      warm      = warm_lvl > half_lvl;
      warm_dist = warm ? warm_lvl - half_lvl : half_lvl - warm_lvl;
      boost     = BW'(warm_dist) * BW'(rca_pkg::K_FOUR);
      cut       = BW'(warm_dist) * BW'(rca_pkg::K_THREE);
      fact_up  = rca_pkg::fact_type'(rca_pkg::ONE_Q) + rca_pkg::fact_type'(boost >> FB);
      fact_dn  = rca_pkg::fact_type'(rca_pkg::ONE_Q) - rca_pkg::fact_type'(cut >> FB);
      fr_in    = warm ? fact_up : fact_dn;
      fb_in    = warm ? fact_dn : fact_up;
      pix0_in[0] = in_pix.red;
      pix0_in[1] = in_pix.green;
      pix0_in[2] = in_pix.blue;

      c2_in[0] = rca_pkg::chan_type'(rca_pkg::prod_type'($signed({1'b0, pix0_ff[0]}))
                 * rca_pkg::prod_type'(fr_ff));
      c2_in[1] = rca_pkg::chan_type'({1'b0, pix0_ff[1]}) <<< FB;
      c2_in[2] = rca_pkg::chan_type'(rca_pkg::prod_type'($signed({1'b0, pix0_ff[2]}))
                 * rca_pkg::prod_type'(fb_ff));

      luma_sum = lp_ff[0] + lp_ff[1] + lp_ff[2];
      y_in     = rca_pkg::chan_type'(luma_sum >>> FB);
      y9_in    = y_ff;
      y10_in   = y9_ff;

      for (int k = 0; k < NC; k++) begin
         pe_in[k] = rca_pkg::prod_type'(c2_ff[k])
                    * rca_pkg::prod_type'($signed({1'b0, cfg.exposure_gain}));
         dc_in[k] = rca_pkg::chan_type'(pe_ff[k] >>> FB) - rca_pkg::chan_type'(rca_pkg::MID_Q);
         pc_in[k] = rca_pkg::prod_type'(dc_ff[k])
                    * rca_pkg::prod_type'($signed({1'b0, cfg.contrast_gain}));
         t6_in[k] = rca_pkg::chan_type'(pc_ff[k] >>> FB) + rca_pkg::chan_type'(rca_pkg::MID_Q);
         lp_in[k] = rca_pkg::prod_type'(t6_ff[k]) * coef[k];
         t7_in[k] = t6_ff[k];
         t8_in[k] = t7_ff[k];
         sd_in[k] = t8_ff[k] - y_ff;
         ps_in[k] = rca_pkg::prod_type'(sd_ff[k])
                    * rca_pkg::prod_type'($signed({1'b0, cfg.saturation_gain}));
         mix[k]   = y10_ff + rca_pkg::chan_type'(ps_ff[k] >>> FB);
         priority if (mix[k][rca_pkg::CH_W-1]) begin
            lvl_in[k] = '0;
         end else if (mix[k] >= rca_pkg::chan_type'(rca_pkg::TOP_Q)) begin
            lvl_in[k] = '1;
         end else begin
            lvl_in[k] = mix[k][FB+rca_pkg::BYTE_W-1:FB];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         last_ff <= last_in;
         fr_ff   <= fr_in;
         fb_ff   <= fb_in;
         y_ff    <= y_in;
         y9_ff   <= y9_in;
         y10_ff  <= y10_in;
         for (int k = 0; k < NC; k++) begin
            pix0_ff[k] <= pix0_in[k];
            c2_ff[k]   <= c2_in[k];
            pe_ff[k]   <= pe_in[k];
            dc_ff[k]   <= dc_in[k];
            pc_ff[k]   <= pc_in[k];
            t6_ff[k]   <= t6_in[k];
            lp_ff[k]   <= lp_in[k];
            t7_ff[k]   <= t7_in[k];
            t8_ff[k]   <= t8_in[k];
            sd_ff[k]   <= sd_in[k];
            ps_ff[k]   <= ps_in[k];
            lvl_ff[k]  <= lvl_in[k];
         end
      end
   end

   assign out_valid     = vld_ff[NSTAGE-1];
   assign out_pix.last  = last_ff[NSTAGE-1];
   assign out_pix.red   = lvl_ff[0];
   assign out_pix.green = lvl_ff[1];
   assign out_pix.blue  = lvl_ff[2];

   // The warmth factors always lie on opposite sides of unity.
   a_warmth_sides: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |->
         (fr_ff >= rca_pkg::fact_type'(rca_pkg::ONE_Q) &&
          fb_ff <= rca_pkg::fact_type'(rca_pkg::ONE_Q)) ||
         (fr_ff <= rca_pkg::fact_type'(rca_pkg::ONE_Q) &&
          fb_ff >= rca_pkg::fact_type'(rca_pkg::ONE_Q)))
      else $error("warmth factors on the same side of unity");

   // Luma is a weighted mean, so it lies between the smallest and largest channel.
   a_luma_bounds: assert property (@(posedge clock) disable iff (reset)
      vld_ff[7] |->
         (y_ff >= t8_ff[0] || y_ff >= t8_ff[1] || y_ff >= t8_ff[2]) &&
         (y_ff <= t8_ff[0] || y_ff <= t8_ff[1] || y_ff <= t8_ff[2]))
      else $error("luma outside the channel range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (vld_ff == '0))
      else $error("pipeline holds a transaction after reset");

endmodule

`default_nettype wire

/* rtl/core/rgb_color_adjust_unit.sv */
// ---------------------------------------------------------------------------
// rgb_color_adjust_unit: per-pixel warmth, exposure, contrast and saturation
// Stream in, stream out, with an APB-style register port for the settings.
// ---------------------------------------------------------------------------
// The unit accepts one RGB888 pixel per clock and returns each adjusted pixel
// in order, with its frame-end flag in tlast, once it has passed the
// eleven-stage arithmetic pipeline. The pipeline holds as a whole while a
// result waits on rsp_tready, so the throughput is one pixel per clock
// whenever the output side takes results.
// Registers: exposure_gain at 0x0, contrast_gain at 0x4, saturation_gain at
// 0x8 and warmth_level at 0xC, 13 bits each with 12 fraction bits; change
// them only while no pixel is in flight.
`default_nettype none

module rgb_color_adjust_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [23:0]                        req_tdata,  // red_in, green_in, blue_in
   input  wire logic                               req_tlast,  // frame_end
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [23:0]                             rsp_tdata,  // red_out, green_out, blue_out
   output logic                                    rsp_tlast,  // frame_end_out
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [rca_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [rca_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rca_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                    csr_pready
);

   rca_pkg::cfg_type     cfg_ff, cfg_in;
   rca_pkg::reg_idx_type csr_idx;
   logic                 csr_wr;
   logic [rca_pkg::REG_W-1:0] wr_val;
   logic                 en;
   rca_pkg::pix_type     in_pix, out_pix;

   assign csr_pready = 1'b1;
   assign csr_idx    = rca_pkg::reg_idx_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign wr_val     = csr_pwdata[rca_pkg::REG_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            rca_pkg::REG_EXPOSURE:   cfg_in.exposure_gain   = wr_val;
            rca_pkg::REG_CONTRAST:   cfg_in.contrast_gain   = wr_val;
            rca_pkg::REG_SATURATION: cfg_in.saturation_gain = wr_val;
            rca_pkg::REG_WARMTH:     cfg_in.warmth_level    = wr_val;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         rca_pkg::REG_EXPOSURE:   csr_prdata = rca_pkg::CSR_DATA_W'(cfg_ff.exposure_gain);
         rca_pkg::REG_CONTRAST:   csr_prdata = rca_pkg::CSR_DATA_W'(cfg_ff.contrast_gain);
         rca_pkg::REG_SATURATION: csr_prdata = rca_pkg::CSR_DATA_W'(cfg_ff.saturation_gain);
         rca_pkg::REG_WARMTH:     csr_prdata = rca_pkg::CSR_DATA_W'(cfg_ff.warmth_level);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.exposure_gain   <= rca_pkg::EXPOSURE_RST;
         cfg_ff.contrast_gain   <= rca_pkg::CONTRAST_RST;
         cfg_ff.saturation_gain <= rca_pkg::SATURATION_RST;
         cfg_ff.warmth_level    <= rca_pkg::WARMTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   assign in_pix.red   = req_tdata[7:0];
   assign in_pix.green = req_tdata[15:8];
   assign in_pix.blue  = req_tdata[23:16];
   assign in_pix.last  = req_tlast;

   rca_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_pix    (in_pix),
      .cfg       (cfg_ff),
      .out_valid (rsp_tvalid),
      .out_pix   (out_pix)
   );

   assign rsp_tdata = {out_pix.blue, out_pix.green, out_pix.red};
   assign rsp_tlast = out_pix.last;

endmodule

`default_nettype wire
